// ===== rtl/hcbd_pkg.sv =====
// Shared types, codes and constants for the chunked body decoder.
// No dependencies; every other file in rtl/ refers to it by scoped name.
package hcbd_pkg;

    localparam logic [7:0]  CH_CR           = 8'h0D;
    localparam logic [7:0]  CH_LF           = 8'h0A;
    localparam logic [7:0]  CH_COLON        = 8'h3A;
    localparam logic [7:0]  CH_SEMI         = 8'h3B;
    localparam logic [31:0] MAX_CHUNK_RESET = 32'd4194304;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_DATA    = 3'd1,
        PH_DATA_CR = 3'd2,
        PH_DATA_LF = 3'd3,
        PH_TRAILER = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_PROGRESS = 2'd0,
        ST_DONE     = 2'd1,
        ST_ERROR    = 2'd2
    } t_status;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       chunk_last;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_digit(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b inside {[8'h30:8'h39]}) begin
            h.val = 4'(b - 8'h30);
        end else if (b inside {[8'h61:8'h66]}) begin
            h.val = 4'(b - 8'h61 + 8'd10);
        end else if (b inside {[8'h41:8'h46]}) begin
            h.val = 4'(b - 8'h41 + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== rtl/hcbd_stream_if.sv =====
// Valid/ready stream interfaces for raw body bytes and decoded results.
// Depends on hcbd_pkg for the result type.
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface hcbd_out_if;
    logic              valid;
    logic              ready;
    hcbd_pkg::t_result result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

// ===== rtl/http_chunked_body_decoder.sv =====
// Top level of the HTTP/1.1 chunked body decoder.
// Depends on hcbd_pkg and the stream interfaces in hcbd_stream_if.sv.
//
// Usage:
//   i_in carries raw body bytes, one per transfer. o_out carries one result
//   per input transfer: payload_valid/payload_byte/chunk_last for decoded
//   body bytes, and status (in progress, body complete, framing error).
//   i_cfg_we/i_cfg_wdata write the chunk size limit; write only while idle.
// Output: the result for a byte is registered and sits in the output
//   register in the cycle after its transfer.
// Throughput: one byte per cycle while o_out.ready is high. The framing
//   state is updated in a single pass of the per-byte logic; the 36-bit
//   size grow-and-compare against the chunk size limit is the longest path.
// Stall: the output register holds its result while o_out.ready is low; a
//   new byte is taken whenever the register is empty or drains this cycle,
//   so back-to-back transfers keep flowing when the receiver keeps up.
// Reset: synchronous, active low; the decoder returns to the size line,
//   all line flags clear, the output register empties and the chunk size
//   limit returns to 4 MiB.
// After body complete or an error, bytes are still taken and yield a
//   result with no payload and the sticky status.
module http_chunked_body_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    hcbd_in_if.sink             i_in,
    hcbd_out_if.source          o_out
);

    // framing state
    hcbd_pkg::t_phase  r_phase, n_phase;
    logic [31:0]       r_size_accum, n_size_accum;
    logic [31:0]       r_bytes_left, n_bytes_left;
    logic              r_pending_cr, n_pending_cr;
    logic              r_in_ext, n_in_ext;
    logic              r_seen_digit, n_seen_digit;
    logic              r_line_nonempty, n_line_nonempty;
    logic              r_line_has_colon, n_line_has_colon;
    logic [31:0]       r_max_chunk;

    // output register
    logic              r_out_valid;
    hcbd_pkg::t_result r_result, n_result;

    logic              in_xfer;
    logic [7:0]        b;
    hcbd_pkg::t_hex    hex;
    logic [35:0]       grown;
    logic              stop;

    // take a byte whenever the output register is free or being drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign b          = i_in.in_byte;
    assign hex        = hcbd_pkg::hex_digit(b);
    assign grown      = {r_size_accum, hex.val};

    assign o_out.valid  = r_out_valid;
    assign o_out.result = r_result;

    always_comb begin
        n_phase          = r_phase;
        n_size_accum     = r_size_accum;
        n_bytes_left     = r_bytes_left;
        n_pending_cr     = r_pending_cr;
        n_in_ext         = r_in_ext;
        n_seen_digit     = r_seen_digit;
        n_line_nonempty  = r_line_nonempty;
        n_line_has_colon = r_line_has_colon;
        n_result         = '0;
        stop             = 1'b0;

        case (r_phase)
            hcbd_pkg::PH_SIZE: begin
                if (r_pending_cr) begin
                    n_pending_cr = 1'b0;
                    if (b == hcbd_pkg::CH_LF) begin
                        stop = 1'b1;
                        if (!r_seen_digit) begin
                            n_phase = hcbd_pkg::PH_ERROR;
                        end else if (r_size_accum == 32'd0) begin
                            // zero chunk: start trailers on a fresh line
                            n_size_accum     = '0;
                            n_in_ext         = 1'b0;
                            n_seen_digit     = 1'b0;
                            n_line_nonempty  = 1'b0;
                            n_line_has_colon = 1'b0;
                            n_phase          = hcbd_pkg::PH_TRAILER;
                        end else begin
                            n_bytes_left = r_size_accum;
                            n_phase      = hcbd_pkg::PH_DATA;
                        end
                    end else if (!r_in_ext) begin
                        // lone CR before the extension is not hex
                        stop    = 1'b1;
                        n_phase = hcbd_pkg::PH_ERROR;
                    end
                end
                if (!stop) begin
                    if (b == hcbd_pkg::CH_CR) begin
                        n_pending_cr = 1'b1;
                    end else if (r_in_ext) begin
                        // extension bytes are dropped
                    end else if (b == hcbd_pkg::CH_SEMI) begin
                        n_in_ext = 1'b1;
                    end else if (!hex.ok) begin
                        n_phase = hcbd_pkg::PH_ERROR;
                    end else if (grown > {4'd0, r_max_chunk}) begin
                        n_phase = hcbd_pkg::PH_ERROR;
                    end else begin
                        n_size_accum = grown[31:0];
                        n_seen_digit = 1'b1;
                    end
                end
            end
            hcbd_pkg::PH_DATA: begin
                n_result.payload_valid = 1'b1;
                n_result.payload_byte  = b;
                n_bytes_left           = r_bytes_left - 32'd1;
                if (r_bytes_left == 32'd1) begin
                    n_result.chunk_last = 1'b1;
                    n_phase             = hcbd_pkg::PH_DATA_CR;
                end
            end
            hcbd_pkg::PH_DATA_CR: begin
                n_phase = (b == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_DATA_LF
                                                 : hcbd_pkg::PH_ERROR;
            end
            hcbd_pkg::PH_DATA_LF: begin
                if (b == hcbd_pkg::CH_LF) begin
                    n_size_accum     = '0;
                    n_pending_cr     = 1'b0;
                    n_in_ext         = 1'b0;
                    n_seen_digit     = 1'b0;
                    n_line_nonempty  = 1'b0;
                    n_line_has_colon = 1'b0;
                    n_phase          = hcbd_pkg::PH_SIZE;
                end else begin
                    n_phase = hcbd_pkg::PH_ERROR;
                end
            end
            hcbd_pkg::PH_TRAILER: begin
                if (r_pending_cr) begin
                    n_pending_cr = 1'b0;
                    if (b == hcbd_pkg::CH_LF) begin
                        stop = 1'b1;
                        if (!r_line_nonempty) begin
                            n_phase = hcbd_pkg::PH_DONE;
                        end else if (!r_line_has_colon) begin
                            n_phase = hcbd_pkg::PH_ERROR;
                        end else begin
                            n_size_accum     = '0;
                            n_in_ext         = 1'b0;
                            n_seen_digit     = 1'b0;
                            n_line_nonempty  = 1'b0;
                            n_line_has_colon = 1'b0;
                        end
                    end else begin
                        n_line_nonempty = 1'b1;
                    end
                end
                if (!stop) begin
                    if (b == hcbd_pkg::CH_CR) begin
                        n_pending_cr = 1'b1;
                    end else begin
                        n_line_nonempty = 1'b1;
                        if (b == hcbd_pkg::CH_COLON) begin
                            n_line_has_colon = 1'b1;
                        end
                    end
                end
            end
            hcbd_pkg::PH_DONE: begin
                // hold: bytes after completion are ignored
            end
            default: begin
                n_phase = hcbd_pkg::PH_ERROR;
            end
        endcase

        if (n_phase == hcbd_pkg::PH_DONE) begin
            n_result.status = hcbd_pkg::ST_DONE;
        end else if (n_phase == hcbd_pkg::PH_ERROR) begin
            n_result.status = hcbd_pkg::ST_ERROR;
        end else begin
            n_result.status = hcbd_pkg::ST_PROGRESS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= hcbd_pkg::PH_SIZE;
            r_size_accum     <= '0;
            r_bytes_left     <= '0;
            r_pending_cr     <= 1'b0;
            r_in_ext         <= 1'b0;
            r_seen_digit     <= 1'b0;
            r_line_nonempty  <= 1'b0;
            r_line_has_colon <= 1'b0;
            r_max_chunk      <= hcbd_pkg::MAX_CHUNK_RESET;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_chunk <= i_cfg_wdata;
            end
            if (in_xfer) begin
                r_phase          <= n_phase;
                r_size_accum     <= n_size_accum;
                r_bytes_left     <= n_bytes_left;
                r_pending_cr     <= n_pending_cr;
                r_in_ext         <= n_in_ext;
                r_seen_digit     <= n_seen_digit;
                r_line_nonempty  <= n_line_nonempty;
                r_line_has_colon <= n_line_has_colon;
                r_out_valid      <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload register: load on every input transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= n_result;
        end
    end

    // a decoded byte never comes with a finished or failed body
    a_payload_in_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.payload_valid) |->
            (r_result.status == hcbd_pkg::ST_PROGRESS))
        else $error("payload byte carries a final status");

    // empty payload fields read as zero
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_result.payload_valid) |->
            (r_result.payload_byte == 8'd0 && !r_result.chunk_last))
        else $error("payload fields not zero without a payload byte");

    // errors are sticky
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hcbd_pkg::PH_ERROR) |=> (r_phase == hcbd_pkg::PH_ERROR))
        else $error("left the error phase");

    // a byte taken after completion reports completion and no payload
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_phase == hcbd_pkg::PH_DONE) |=>
            (r_result.status == hcbd_pkg::ST_DONE && !r_result.payload_valid))
        else $error("byte after completion changed the result");

endmodule
